FILE: hdl/assert_macros.svh
// Assertion macros used by bis_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define CHK_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/bis_pkg.sv
// Types, constants and codes of the bilinear RGB image scaler.
package bis_pkg;

  localparam int DEF_MAX_SRC_W = 256;
  localparam int DEF_MAX_SRC_H = 256;

  localparam int COORD_W    = 12;
  localparam int SRC_W      = 9;
  localparam int DEN_W      = 13;
  localparam int FRAC_W     = 7;
  localparam int NUM_W      = COORD_W + FRAC_W + SRC_W;
  localparam int POS_W      = NUM_W - FRAC_W + 2;
  localparam int MODE_W     = 4;
  localparam int LEVEL_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int PIX_W      = 24;
  localparam int WT_W       = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 3'd0,
    CFG_SOURCE_HEIGHT = 3'd1,
    CFG_DEST_WIDTH    = 3'd2,
    CFG_DEST_HEIGHT   = 3'd3,
    CFG_MODE_FLAGS    = 3'd4,
    CFG_SHADOW_LEVEL  = 3'd5
  } cfg_reg_e;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  localparam int MODE_MIRROR_X = 0;
  localparam int MODE_MIRROR_Y = 1;
  localparam int MODE_GRAY     = 2;
  localparam int MODE_SHADOW   = 3;

  localparam logic [SRC_W-1:0]   RST_SRC_W = 9'd256;
  localparam logic [SRC_W-1:0]   RST_SRC_H = 9'd256;
  localparam logic [DEN_W-1:0]   RST_DST_W = 13'd256;
  localparam logic [DEN_W-1:0]   RST_DST_H = 13'd256;
  localparam logic [MODE_W-1:0]  RST_MODE  = 4'd0;
  localparam logic [LEVEL_W-1:0] RST_LEVEL = 11'd1024;

  localparam logic [9:0] GRAY_R = 10'd215;
  localparam logic [9:0] GRAY_G = 10'd737;
  localparam logic [9:0] GRAY_B = 10'd72;

  typedef struct packed {
    logic                opcode;
    logic [COORD_W-1:0]  x_pos;
    logic [COORD_W-1:0]  y_pos;
    logic [7:0]          red_in;
    logic [7:0]          green_in;
    logic [7:0]          blue_in;
  } cmd_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } res_t;

endpackage

FILE: hdl/bis_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
module bis_div #(
  parameter int NUM_W = bis_pkg::NUM_W,
  parameter int DEN_W = bis_pkg::DEN_W,
  parameter int SB_W  = $bits(bis_pkg::cmd_t)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [1:0][NUM_W-1:0] num,
  input  logic [1:0][DEN_W-1:0] den,
  input  logic [SB_W-1:0]       sb_in,
  output logic                  out_valid,
  output logic [1:0][NUM_W-1:0] quo,
  output logic [SB_W-1:0]       sb_out
);
  logic                  v_s   [0:NUM_W];
  logic [1:0][NUM_W-1:0] num_s [0:NUM_W];
  logic [1:0][NUM_W-1:0] quo_s [0:NUM_W];
  logic [1:0][DEN_W-1:0] rem_s [0:NUM_W];
  logic [1:0][DEN_W-1:0] den_s [0:NUM_W];
  logic [SB_W-1:0]       sb_s  [0:NUM_W];

  always_comb begin
    v_s[0]   = in_valid;
    num_s[0] = num;
    quo_s[0] = '0;
    rem_s[0] = '0;
    den_s[0] = den;
    sb_s[0]  = sb_in;
  end

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [1:0][DEN_W:0]   trial;
    logic [1:0][DEN_W:0]   diff;
    logic [1:0]            ge;
    logic [1:0][DEN_W-1:0] rem_next;

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l]    = {rem_s[i][l], num_s[i][l][NUM_W-1]};
        diff[l]     = trial[l] - {1'b0, den_s[i][l]};
        ge[l]       = trial[l] >= {1'b0, den_s[i][l]};
        rem_next[l] = ge[l] ? diff[l][DEN_W-1:0] : trial[l][DEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i+1] <= 1'b0;
      end else if (en) begin
        v_s[i+1] <= v_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          num_s[i+1][l] <= {num_s[i][l][NUM_W-2:0], 1'b0};
          quo_s[i+1][l] <= {quo_s[i][l][NUM_W-2:0], ge[l]};
          rem_s[i+1][l] <= rem_next[l];
        end
        den_s[i+1] <= den_s[i];
        sb_s[i+1]  <= sb_s[i];
      end
    end
  end

  assign out_valid = v_s[NUM_W];
  assign quo       = quo_s[NUM_W];
  assign sb_out    = sb_s[NUM_W];

endmodule

FILE: hdl/bilinear_rgb_image_scaler.sv
// Bilinear RGB image scaler: source image store and resampling pipeline.
// The block takes one item per clock while no result is stalled, loads and renders mixed in
// any order, and gives one result per render. A render passes one input register, one
// multiply stage for the source position numerators, one stage per quotient bit of the two
// position dividers, then tap selection, the memory read, the weight multiply, the channel
// sum, the gray multiply, the gray select and the output register, which takes the shadow
// scaling. The image lies in four banks split by the parity of x and y, so the four
// neighbors of a render are read in the same cycle; loads write at the same pipeline stage
// where renders read, which keeps program order. A stalled result holds the whole pipeline.
// Pixels not yet loaded read as anything.
module bilinear_rgb_image_scaler #(
  parameter int MAX_SOURCE_WIDTH  = bis_pkg::DEF_MAX_SRC_W,
  parameter int MAX_SOURCE_HEIGHT = bis_pkg::DEF_MAX_SRC_H
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  bis_pkg::cmd_t                  cmd,
  output logic                           res_valid,
  input  logic                           res_stall,
  output bis_pkg::res_t                  res
);
  import bis_pkg::*;

  localparam int SW_CAP  = (MAX_SOURCE_WIDTH > 511) ? 511 : MAX_SOURCE_WIDTH;
  localparam int SH_CAP  = (MAX_SOURCE_HEIGHT > 511) ? 511 : MAX_SOURCE_HEIGHT;
  localparam int HXW     = ($clog2(MAX_SOURCE_WIDTH) > 1) ? $clog2(MAX_SOURCE_WIDTH) - 1 : 1;
  localparam int HYW     = ($clog2(MAX_SOURCE_HEIGHT) > 1) ? $clog2(MAX_SOURCE_HEIGHT) - 1 : 1;
  localparam int BANK_AW = HXW + HYW;
  localparam int BANK_D  = 1 << BANK_AW;

  typedef struct packed {
    logic signed [POS_W-1:0] p1;
    logic signed [POS_W-1:0] p2;
    logic [7:0]              w1;
    logic [7:0]              w2;
  } axis_t;

  function automatic axis_t axis_taps(input logic [NUM_W-1:0] q,
                                      input logic [SRC_W-1:0] src,
                                      input logic mir);
    axis_t                   a;
    logic [FRAC_W-1:0]       f;
    logic signed [POS_W-1:0] s;
    logic signed [POS_W-1:0] src_s;
    logic                    lo;
    f     = q[FRAC_W-1:0];
    s     = POS_W'(q[NUM_W-1:FRAC_W]);
    src_s = POS_W'(src);
    if (mir) begin
      s = src_s - POS_W'(1) - s;
    end
    lo   = f <= 7'd64;
    a.p1 = s;
    a.p2 = (lo ^ mir) ? s - POS_W'(1) : s + POS_W'(1);
    a.w1 = lo ? 8'd64 + {1'b0, f} : 8'd192 - {1'b0, f};
    a.w2 = lo ? 8'd64 - {1'b0, f} : {1'b0, f} - 8'd64;
    return a;
  endfunction

  // Configuration registers.
  logic [SRC_W-1:0]   src_w, src_h;
  logic [DEN_W-1:0]   dst_w, dst_h;
  logic [MODE_W-1:0]  mode;
  logic [LEVEL_W-1:0] level;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= RST_SRC_W;
      src_h <= RST_SRC_H;
      dst_w <= RST_DST_W;
      dst_h <= RST_DST_H;
      mode  <= RST_MODE;
      level <= RST_LEVEL;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SOURCE_WIDTH:  src_w <= cfg_data[SRC_W-1:0];
        CFG_SOURCE_HEIGHT: src_h <= cfg_data[SRC_W-1:0];
        CFG_DEST_WIDTH:    dst_w <= cfg_data[DEN_W-1:0];
        CFG_DEST_HEIGHT:   dst_h <= cfg_data[DEN_W-1:0];
        CFG_MODE_FLAGS:    mode  <= cfg_data[MODE_W-1:0];
        CFG_SHADOW_LEVEL:  level <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SRC_W-1:0]        sw_eff, sh_eff;
  logic signed [POS_W-1:0] sw_s, sh_s;
  logic                    adv;

  assign sw_eff    = (src_w > SRC_W'(SW_CAP)) ? SRC_W'(SW_CAP) : src_w;
  assign sh_eff    = (src_h > SRC_W'(SH_CAP)) ? SRC_W'(SH_CAP) : src_h;
  assign sw_s      = POS_W'(sw_eff);
  assign sh_s      = POS_W'(sh_eff);
  assign adv       = !(res_valid && res_stall);
  assign cmd_stall = !adv;

  // Input register and numerator multiply.
  logic                  v0, v1;
  cmd_t                  c0, c1;
  logic [1:0][NUM_W-1:0] num1;
  logic [1:0][DEN_W-1:0] den1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (adv) begin
      v0 <= cmd_valid;
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c0      <= cmd;
      c1      <= c0;
      num1[0] <= NUM_W'({c0.x_pos, 7'b1000000}) * NUM_W'(sw_eff);
      num1[1] <= NUM_W'({c0.y_pos, 7'b1000000}) * NUM_W'(sh_eff);
      den1[0] <= (dst_w == '0) ? DEN_W'(1) : dst_w;
      den1[1] <= (dst_h == '0) ? DEN_W'(1) : dst_h;
    end
  end

  logic                  vq;
  logic [1:0][NUM_W-1:0] quo;
  cmd_t                  cq;

  bis_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .SB_W  ($bits(cmd_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v1),
    .num       (num1),
    .den       (den1),
    .sb_in     (c1),
    .out_valid (vq),
    .quo       (quo),
    .sb_out    (cq)
  );

  // Tap positions and weights along each axis.
  logic  v_t1;
  cmd_t  c_t1;
  axis_t ax_x, ax_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_t1 <= 1'b0;
    end else if (adv) begin
      v_t1 <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_t1 <= cq;
      ax_x <= axis_taps(quo[0], sw_eff, mode[MODE_MIRROR_X]);
      ax_y <= axis_taps(quo[1], sh_eff, mode[MODE_MIRROR_Y]);
    end
  end

  // One neighbor per bank: bank index is {y parity, x parity}.
  logic [BANK_AW-1:0] rd_addr [4];
  logic [WT_W-1:0]    wt_next [4];
  logic [BANK_AW-1:0] ld_addr;
  logic [1:0]         ld_bank;
  logic               ld_en;

  always_comb begin
    logic signed [POS_W-1:0] xs, ys;
    logic [7:0]              wx, wy;
    logic                    inr;
    for (int b = 0; b < 4; b++) begin
      xs = (ax_x.p1[0] == b[0]) ? ax_x.p1 : ax_x.p2;
      wx = (ax_x.p1[0] == b[0]) ? ax_x.w1 : ax_x.w2;
      ys = (ax_y.p1[0] == b[1]) ? ax_y.p1 : ax_y.p2;
      wy = (ax_y.p1[0] == b[1]) ? ax_y.w1 : ax_y.w2;
      inr = !xs[POS_W-1] && !ys[POS_W-1] && (xs < sw_s) && (ys < sh_s);
      rd_addr[b] = {ys[HYW:1], xs[HXW:1]};
      wt_next[b] = inr ? WT_W'(wx * wy) : '0;
    end
    ld_addr = {c_t1.y_pos[HYW:1], c_t1.x_pos[HXW:1]};
    ld_bank = {c_t1.y_pos[0], c_t1.x_pos[0]};
    ld_en   = adv && v_t1 && (c_t1.opcode == OP_LOAD) &&
              (c_t1.x_pos < COORD_W'(sw_eff)) && (c_t1.y_pos < COORD_W'(sh_eff));
  end

  logic [PIX_W-1:0] rdata [4];
  logic [WT_W-1:0]  wt    [4];
  logic             r_t2;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0] mem [BANK_D];

    always_ff @(posedge clk) begin
      if (ld_en && ld_bank == 2'(b)) begin
        mem[ld_addr] <= {c_t1.red_in, c_t1.green_in, c_t1.blue_in};
      end
      if (adv) begin
        rdata[b] <= mem[rd_addr[b]];
        wt[b]    <= wt_next[b];
      end
    end
  end

  // Weighting, sum, gray and shadow stages.
  logic             r_t3, r_t4, r_t5, r_t6;
  logic [22:0]      prod [4][3];
  logic [7:0]       acc  [3];
  logic [7:0]       acc5 [3];
  logic [17:0]      gp   [3];
  logic [7:0]       val  [3];
  logic [24:0]      csum [3];
  logic [17:0]      gsum;
  logic [18:0]      shp  [3];
  logic [7:0]       outc [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      csum[c] = 25'(prod[0][c]) + 25'(prod[1][c]) + 25'(prod[2][c]) + 25'(prod[3][c]);
      shp[c]  = 19'(val[c]) * 19'(level);
      outc[c] = (shp[c][18:10] > 9'd255) ? 8'd255 : shp[c][17:10];
      if (!mode[MODE_SHADOW]) begin
        outc[c] = val[c];
      end
    end
    gsum = gp[0] + gp[1] + gp[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_t2      <= 1'b0;
      r_t3      <= 1'b0;
      r_t4      <= 1'b0;
      r_t5      <= 1'b0;
      r_t6      <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      r_t2      <= v_t1 && (c_t1.opcode == OP_RENDER);
      r_t3      <= r_t2;
      r_t4      <= r_t3;
      r_t5      <= r_t4;
      r_t6      <= r_t5;
      res_valid <= r_t6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Drop a neighbor with no weight outright so its data never leaks in.
      for (int b = 0; b < 4; b++) begin
        for (int c = 0; c < 3; c++) begin
          prod[b][c] <= (wt[b] == '0) ? '0 :
                        23'(rdata[b][PIX_W-1-8*c -: 8]) * 23'(wt[b]);
        end
      end
      for (int c = 0; c < 3; c++) begin
        acc[c]  <= csum[c][21:14];
        acc5[c] <= acc[c];
        val[c]  <= mode[MODE_GRAY] ? gsum[17:10] : acc5[c];
      end
      gp[0] <= 18'(acc[0]) * 18'(GRAY_R);
      gp[1] <= 18'(acc[1]) * 18'(GRAY_G);
      gp[2] <= 18'(acc[2]) * 18'(GRAY_B);
      res.red_out   <= outc[0];
      res.green_out <= outc[1];
      res.blue_out  <= outc[2];
    end
  end

endmodule

FILE: hdl/bis_checker.sv
// Port-level checks on the bilinear RGB image scaler, attached by bind.
`include "assert_macros.svh"

module bis_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_stall,
  input logic          res_valid,
  input logic          res_stall,
  input bis_pkg::res_t res
);
  import bis_pkg::*;

  `CHK_ASSERT(a_res_hold, clk, rst, res_valid && res_stall |=> res_valid && $stable(res), "result item changed while stalled")
  `CHK_ASSERT_NR(a_rst_idle, clk, $past(rst) |-> !res_valid, "result item valid right after reset")
  `CHK_ASSERT_NR(a_stall_src, clk, cmd_stall == (res_valid && res_stall), "input stall not tied to a held result item")

endmodule

bind bilinear_rgb_image_scaler bis_checker u_bis_checker (.*);

FILE: tb/bilinear_rgb_image_scaler_checker.sv
// Checker for the bilinear RGB image scaler: predicts each resampled pixel and compares.
`timescale 1ns / 100ps

module bilinear_rgb_image_scaler_checker
  import bis_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  cmd_valid,
  input  logic                  cmd_stall,
  input  cmd_t                  cmd,
  input  logic                  res_valid,
  input  logic                  res_stall,
  input  res_t                  res,
  output int                    errors,
  output int                    pending
);

  localparam int IMG_W = DEF_MAX_SRC_W;
  localparam int IMG_H = DEF_MAX_SRC_H;

  logic [SRC_W-1:0]   src_w_reg;
  logic [SRC_W-1:0]   src_h_reg;
  logic [DEN_W-1:0]   dst_w_reg;
  logic [DEN_W-1:0]   dst_h_reg;
  logic [MODE_W-1:0]  mode_reg;
  logic [LEVEL_W-1:0] level_reg;
  logic [PIX_W-1:0]   image_mem [0:IMG_W*IMG_H-1];
  res_t               expected_pixels [$];

  // Two taps along one axis: positions and 1/128 weights.
  function automatic void axis_taps(input int d, input int src, input int dst, input bit mir,
                                    output int p1, output int p2, output int w1,
                                    output int w2);
    longint q;
    int     f;
    int     s;
    int     dir;
    q   = ((longint'(d) * 128 + 64) * src) / (dst == 0 ? 1 : dst);
    f   = int'(q & 127);
    s   = int'(q >> 7);
    dir = 1;
    if (mir) begin
      s   = src - 1 - s;
      dir = -1;
    end
    p1 = s;
    if (f <= 64) begin
      p2 = s - dir;
      w1 = 64 + f;
      w2 = 64 - f;
    end else begin
      p2 = s + dir;
      w1 = 192 - f;
      w2 = f - 64;
    end
  endfunction

  function automatic res_t resample(input int xd, input int yd);
    int   sw, sh, xs[2], ys[2], wx[2], wy[2];
    int   acc[3];
    int   g;
    res_t r;
    logic [PIX_W-1:0] pix;
    sw = (src_w_reg > IMG_W) ? IMG_W : src_w_reg;
    sh = (src_h_reg > IMG_H) ? IMG_H : src_h_reg;
    axis_taps(xd, sw, dst_w_reg, mode_reg[MODE_MIRROR_X], xs[0], xs[1], wx[0], wx[1]);
    axis_taps(yd, sh, dst_h_reg, mode_reg[MODE_MIRROR_Y], ys[0], ys[1], wy[0], wy[1]);
    acc = '{0, 0, 0};
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        if (xs[i] >= 0 && ys[j] >= 0 && xs[i] < sw && ys[j] < sh) begin
          pix = image_mem[ys[j] * IMG_W + xs[i]];
          acc[0] += pix[23:16] * wx[i] * wy[j];
          acc[1] += pix[15:8] * wx[i] * wy[j];
          acc[2] += pix[7:0] * wx[i] * wy[j];
        end
    for (int c = 0; c < 3; c++) acc[c] = acc[c] >> 14;
    if (mode_reg[MODE_GRAY]) begin
      g = (acc[0] * 215 + acc[1] * 737 + acc[2] * 72) >> 10;
      acc = '{g, g, g};
    end
    if (mode_reg[MODE_SHADOW])
      for (int c = 0; c < 3; c++) acc[c] = (acc[c] * level_reg) >> 10;
    r.red_out   = acc[0] > 255 ? 8'hFF : acc[0][7:0];
    r.green_out = acc[1] > 255 ? 8'hFF : acc[1][7:0];
    r.blue_out  = acc[2] > 255 ? 8'hFF : acc[2][7:0];
    return r;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
    for (int i = 0; i < IMG_W * IMG_H; i++) image_mem[i] = '0;
  end

  always @(posedge clk) begin
    res_t want;
    int   sw, sh;
    if (rst) begin
      src_w_reg <= RST_SRC_W;
      src_h_reg <= RST_SRC_H;
      dst_w_reg <= RST_DST_W;
      dst_h_reg <= RST_DST_H;
      mode_reg  <= RST_MODE;
      level_reg <= RST_LEVEL;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_pixels.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected pixel %h at %0t", res, $realtime);
        end else begin
          want = expected_pixels.pop_front();
          if (res.red_out !== want.red_out || res.green_out !== want.green_out ||
              res.blue_out !== want.blue_out) begin
            errors++;
            if (errors <= 10)
              $display("pixel mismatch at %0t: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                       $realtime, want.red_out, want.green_out, want.blue_out,
                       res.red_out, res.green_out, res.blue_out);
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        sw = (src_w_reg > IMG_W) ? IMG_W : src_w_reg;
        sh = (src_h_reg > IMG_H) ? IMG_H : src_h_reg;
        if (cmd.opcode == OP_RENDER)
          expected_pixels.push_back(resample(cmd.x_pos, cmd.y_pos));
        else if (cmd.x_pos < sw && cmd.y_pos < sh)
          image_mem[cmd.y_pos * IMG_W + cmd.x_pos] = {cmd.red_in, cmd.green_in, cmd.blue_in};
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_SOURCE_WIDTH:  src_w_reg <= cfg_data[SRC_W-1:0];
          CFG_SOURCE_HEIGHT: src_h_reg <= cfg_data[SRC_W-1:0];
          CFG_DEST_WIDTH:    dst_w_reg <= cfg_data[DEN_W-1:0];
          CFG_DEST_HEIGHT:   dst_h_reg <= cfg_data[DEN_W-1:0];
          CFG_MODE_FLAGS:    mode_reg  <= cfg_data[MODE_W-1:0];
          CFG_SHADOW_LEVEL:  level_reg <= cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= expected_pixels.size();
  end

endmodule

FILE: tb/bilinear_rgb_image_scaler_tb.sv
// Testbench top of the bilinear RGB image scaler: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module bilinear_rgb_image_scaler_tb;
  import bis_pkg::*;

  localparam int IMG_W = DEF_MAX_SRC_W;
  localparam int IMG_H = DEF_MAX_SRC_H;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  cmd_valid;
  logic                  cmd_stall;
  cmd_t                  cmd;
  logic                  res_valid;
  logic                  res_stall;
  res_t                  res;
  int                    errors;
  int                    pending;

  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;
  bit loaded [0:IMG_W*IMG_H-1];
  int src_w_eff, src_h_eff, dst_w_reg, dst_h_reg, mode_now;

  bilinear_rgb_image_scaler dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  bilinear_rgb_image_scaler_checker u_checker (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .errors(errors), .pending(pending)
  );

  always #6 clk = ~clk;

  initial begin
    #(12 * 2000000);
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_left = 400;
        hold_req  = 1'b0;
        res_stall <= 1'b1;
      end else begin
        res_stall <= idle_on && ($urandom_range(99) < 8);
      end
    end
  end

  // Source rows or columns that one destination coordinate reads.
  function automatic void tap_span(input int d, input int src, input int dst, input bit mir,
                                   output int a, output int b);
    longint q;
    int     s;
    int     dir;
    q   = ((longint'(d) * 128 + 64) * src) / (dst == 0 ? 1 : dst);
    s   = int'(q >> 7);
    dir = 1;
    if (mir) begin
      s   = src - 1 - s;
      dir = -1;
    end
    a = s;
    b = ((q & 127) <= 64) ? s - dir : s + dir;
  endfunction

  task automatic send_item(input cmd_t c);
    bit st;
    if (idle_on && $urandom_range(99) < 8) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do begin
      @(negedge clk);
      st = cmd_stall;
      @(posedge clk);
    end while (st);
  endtask

  task automatic load_pixel(input int x, input int y);
    cmd_t c;
    c.opcode   = OP_LOAD;
    c.x_pos    = COORD_W'(x);
    c.y_pos    = COORD_W'(y);
    c.red_in   = 8'($urandom_range(255));
    c.green_in = 8'($urandom_range(255));
    c.blue_in  = 8'($urandom_range(255));
    send_item(c);
    if (x < src_w_eff && y < src_h_eff) loaded[y * IMG_W + x] = 1'b1;
  endtask

  // Load any neighbor not yet written, then render.
  task automatic render_pixel(input int x, input int y);
    cmd_t c;
    int   xs[2], ys[2];
    tap_span(x, src_w_eff, dst_w_reg, mode_now[MODE_MIRROR_X], xs[0], xs[1]);
    tap_span(y, src_h_eff, dst_h_reg, mode_now[MODE_MIRROR_Y], ys[0], ys[1]);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        if (xs[i] >= 0 && ys[j] >= 0 && xs[i] < src_w_eff && ys[j] < src_h_eff &&
            !loaded[ys[j] * IMG_W + xs[i]])
          load_pixel(xs[i], ys[j]);
    c          = '0;
    c.opcode   = OP_RENDER;
    c.x_pos    = COORD_W'(x);
    c.y_pos    = COORD_W'(y);
    c.red_in   = 8'($urandom_range(255));
    c.green_in = 8'($urandom_range(255));
    c.blue_in  = 8'($urandom_range(255));
    send_item(c);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_regs(input int sw, input int sh, input int dw, input int dh,
                          input int mode, input int lvl);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SOURCE_WIDTH;  cfg_data <= CFG_DATA_W'(sw);   @(posedge clk);
    cfg_index <= CFG_SOURCE_HEIGHT; cfg_data <= CFG_DATA_W'(sh);   @(posedge clk);
    cfg_index <= CFG_DEST_WIDTH;    cfg_data <= CFG_DATA_W'(dw);   @(posedge clk);
    cfg_index <= CFG_DEST_HEIGHT;   cfg_data <= CFG_DATA_W'(dh);   @(posedge clk);
    cfg_index <= CFG_MODE_FLAGS;    cfg_data <= CFG_DATA_W'(mode); @(posedge clk);
    cfg_index <= CFG_SHADOW_LEVEL;  cfg_data <= CFG_DATA_W'(lvl);  @(posedge clk);
    cfg_write <= 1'b0;
    src_w_eff = sw > IMG_W ? IMG_W : sw;
    src_h_eff = sh > IMG_H ? IMG_H : sh;
    dst_w_reg = dw;
    dst_h_reg = dh;
    mode_now  = mode;
  endtask

  task automatic random_items(input int n);
    int x, y, dw, dh;
    repeat (n) begin
      if ($urandom_range(99) < 35) begin
        if ($urandom_range(99) < 10 || src_w_eff == 0 || src_h_eff == 0) begin
          x = $urandom_range(4095);
          y = $urandom_range(4095);
        end else begin
          x = $urandom_range(src_w_eff - 1);
          y = $urandom_range(src_h_eff - 1);
        end
        load_pixel(x, y);
      end else begin
        dw = dst_w_reg == 0 ? 1 : (dst_w_reg > 4096 ? 4096 : dst_w_reg);
        dh = dst_h_reg == 0 ? 1 : (dst_h_reg > 4096 ? 4096 : dst_h_reg);
        x = ($urandom_range(99) < 90) ? $urandom_range(dw - 1) : $urandom_range(4095);
        y = ($urandom_range(99) < 90) ? $urandom_range(dh - 1) : $urandom_range(4095);
        render_pixel(x, y);
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_SOURCE_WIDTH;
    cfg_data  <= '0;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    src_w_eff = IMG_W;
    src_h_eff = IMG_H;
    dst_w_reg = 256;
    dst_h_reg = 256;
    mode_now  = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: corners, ignored loads, far-out renders, extreme register settings.
    load_pixel(0, 0);
    load_pixel(255, 255);
    load_pixel(4095, 4095);
    load_pixel(256, 0);
    render_pixel(0, 0);
    render_pixel(255, 255);
    render_pixel(4095, 4095);
    render_pixel(4095, 0);
    render_pixel(0, 4095);
    drain();
    set_regs(1, 1, 1, 1, 0, 1024);
    load_pixel(0, 0);
    render_pixel(0, 0);
    render_pixel(1, 1);
    drain();
    set_regs(0, 5, 3, 0, 4, 512);
    render_pixel(0, 0);
    render_pixel(2, 3);
    drain();
    set_regs(511, 300, 8191, 7, 15, 2047);
    render_pixel(4095, 6);
    render_pixel(0, 0);
    drain();

    // Random phases over several settings.
    set_regs(256, 256, 4096, 4096, 3, 0);
    random_items(80);
    drain();
    set_regs(8, 6, 20, 13, 12, 1024);
    hold_req = 1'b1;
    random_items(100);
    drain();
    idle_on = 1'b0;
    set_regs(4, 4, 4, 4, 0, 1024);
    random_items(150);
    drain();
    idle_on = 1'b1;
    set_regs(256, 1, 37, 4096, 9, 2047);
    random_items(80);
    drain();
    for (int p = 0; p < 8; p++) begin
      set_regs($urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(1, 64),
               $urandom_range(1, 64), $urandom_range(15), $urandom_range(1024));
      random_items(50);
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
